/* sv/ifds_pkg.sv */
package ifds_pkg;

	// Drain phases of the sequencer.
	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_WD_COUNT    = 4'd1,
		PH_PRE_COUNT   = 4'd2,
		PH_LOOP_COUNT  = 4'd3,
		PH_READING     = 4'd4,
		PH_DELAY       = 4'd5,
		PH_FINAL_COUNT = 4'd6,
		PH_FINAL_CYCLE = 4'd7,
		PH_OVF_CYCLE   = 4'd8,
		PH_ERR_CYCLE   = 4'd9,
		PH_REINIT      = 4'd10
	} phase_t;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_STAMP = 3'b010,
		ST_OUT   = 3'b100
	} ctl_state_t;

	localparam logic [2:0] MODE_IRQ      = 3'd0;
	localparam logic [2:0] MODE_WDOG     = 3'd1;
	localparam logic [2:0] MODE_COUNT    = 3'd2;
	localparam logic [2:0] MODE_DATA     = 3'd3;
	localparam logic [2:0] MODE_CYCLE    = 3'd4;
	localparam logic [2:0] MODE_REINIT   = 3'd5;
	localparam logic [2:0] MODE_DELAY    = 3'd6;
	localparam logic [2:0] MODE_FAIL     = 3'd7;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_COUNT  = 3'd1;
	localparam logic [2:0] ACT_DATA   = 3'd2;
	localparam logic [2:0] ACT_CYCLE  = 3'd3;
	localparam logic [2:0] ACT_REINIT = 3'd4;
	localparam logic [2:0] ACT_WAIT   = 3'd5;
	localparam logic [2:0] ACT_STAMP  = 3'd6;

	localparam logic [2:0] CFG_ENABLED = 3'd0;
	localparam logic [2:0] CFG_PERIOD  = 3'd1;
	localparam logic [2:0] CFG_BURST   = 3'd2;
	localparam logic [2:0] CFG_WDGAP   = 3'd3;
	localparam logic [2:0] CFG_ERRLIM  = 3'd4;

	localparam int WTM_FRAMES  = 2;
	localparam int RETRY_LIMIT = 2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;       // evaluate the accepted item
		logic stamp;      // emit one frame timestamp and advance
		logic stamp_done; // close the burst and issue the trailing command
	} ifds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_stamps; // the evaluated item starts a timestamp burst
		logic stamps_left; // more than one timestamp remains
	} ifds_sts_t;

endpackage

/* sv/ifds_ctrl.sv */
module ifds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_fire,
	input  ifds_pkg::ifds_sts_t sts,
	output ifds_pkg::ifds_cmd_t cmd,
	output logic                busy,
	output logic                out_valid
);

	ifds_pkg::ctl_state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.step = in_fire;
		if (state_q == ifds_pkg::ST_STAMP && out_fire) begin
			if (sts.stamps_left) cmd.stamp = 1'b1;
			else cmd.stamp_done = 1'b1;
		end
	end

	assign busy      = (state_q != ifds_pkg::ST_IDLE);
	assign out_valid = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifds_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				ifds_pkg::ST_IDLE: begin
					if (in_fire)
						state_q <= sts.has_stamps ? ifds_pkg::ST_STAMP : ifds_pkg::ST_OUT;
				end
				ifds_pkg::ST_STAMP: begin
					if (out_fire && !sts.stamps_left) state_q <= ifds_pkg::ST_OUT;
				end
				ifds_pkg::ST_OUT: begin
					if (out_fire) state_q <= ifds_pkg::ST_IDLE;
				end
				default: state_q <= ifds_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/ifds_dp.sv */
module ifds_dp #(
	parameter int MAX_BURST       = 32,
	parameter int MAX_LOOPS       = 16,
	parameter int WORDS_PER_FRAME = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ifds_pkg::ifds_cmd_t cmd,
	output ifds_pkg::ifds_sts_t sts,
	input  logic [2:0]          mode,
	input  logic [62:0]         time_ns,
	input  logic                ovf_flag,
	input  logic [11:0]         word_count,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic [2:0]          action,
	output logic [5:0]          frame_count,
	output logic [63:0]         frame_time,
	output logic                last
);

	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int LW = $clog2(MAX_LOOPS + 1);
	localparam int FW = 12;
	localparam logic [11:0] WTM_WORDS = 12'(ifds_pkg::WTM_FRAMES * WORDS_PER_FRAME);

	// Configuration registers.
	logic        enabled_q;
	logic [26:0] period_q;
	logic [5:0]  burst_q;
	logic [29:0] wdgap_q;
	logic [2:0]  errlim_q;

	ifds_pkg::phase_t phase_q;
	logic        irq_origin_q, read_any_q, irq_pending_q;
	logic [63:0] last_irq_q, anchor_q, first_q;
	logic [9:0]  offset_q;
	logic [LW-1:0] loop_q;
	logic [1:0]  retry_q;
	logic [2:0]  err_q;
	logic [BW-1:0] pend_q;

	// The first timestamp is loaded in the cycle after the count reply, from the
	// period multiple held here.
	logic [FW-1:0] back_q;
	logic        first_ld_q;

	// Remaining timestamps of the burst.
	logic [BW-1:0] stamps_q;

	// Output register.
	logic [2:0]  act_q;
	logic [5:0]  cnt_q;
	logic [63:0] time_q;
	logic        last_q;

	// Deferred command after the stamp burst.
	logic [2:0]  tail_act_q;

	// Frames from words: the word count is 12 bits, so a reciprocal multiply.
	localparam int RSH = 24;
	localparam logic [24:0] RCP = 25'(((1 << RSH) + WORDS_PER_FRAME - 1) / WORDS_PER_FRAME);
	logic [36:0] prod;
	logic [FW-1:0] frames;
	assign prod   = {25'd0, word_count} * {12'd0, RCP};
	assign frames = prod[RSH +: FW];

	// Period multiple subtracted from the anchor for the first timestamp.
	logic [38:0] back_prod;
	assign back_prod = {27'd0, back_q} * {12'd0, period_q};

	logic [BW-1:0] lim;
	always_comb begin
		if (burst_q == 6'd0) lim = BW'(1);
		else if ({26'd0, burst_q} > 32'(MAX_BURST)) lim = BW'(MAX_BURST);
		else lim = BW'(burst_q);
	end

	logic signed [63:0] gap;
	assign gap = $signed(anchor_q) - $signed(last_irq_q);

	// Next-state evaluation of one item.
	ifds_pkg::phase_t n_phase;
	logic        n_origin, n_read_any, n_pend_irq;
	logic [63:0] n_last_irq, n_anchor;
	logic [9:0]  n_offset;
	logic [LW-1:0] n_loop;
	logic [1:0]  n_retry;
	logic [2:0]  n_err;
	logic [BW-1:0] n_pend;
	logic [FW-1:0] n_back;
	logic        n_first_ld;
	logic [2:0]  n_act;
	logic [5:0]  n_cnt;
	logic        do_finish, do_next_loop, do_stamps;
	logic [2:0]  fin_act;
	logic [LW-1:0] loop_inc;

	assign loop_inc = loop_q + LW'(1);

	always_comb begin
		n_phase = phase_q; n_origin = irq_origin_q; n_read_any = read_any_q;
		n_pend_irq = irq_pending_q; n_last_irq = last_irq_q; n_anchor = anchor_q;
		n_offset = offset_q; n_loop = loop_q; n_retry = retry_q;
		n_err = err_q; n_pend = pend_q; n_act = ifds_pkg::ACT_NONE; n_cnt = 6'd0;
		n_back = back_q; n_first_ld = 1'b0;
		do_finish = 1'b0; do_next_loop = 1'b0; do_stamps = 1'b0;
		case (mode)
			ifds_pkg::MODE_IRQ: begin
				if (enabled_q) begin
					n_last_irq = {1'b0, time_ns};
					if (phase_q == ifds_pkg::PH_IDLE) begin
						n_origin = 1'b1; n_anchor = {1'b0, time_ns};
						n_phase = ifds_pkg::PH_PRE_COUNT; n_act = ifds_pkg::ACT_COUNT;
					end else begin
						n_pend_irq = 1'b1;
					end
				end
			end
			ifds_pkg::MODE_WDOG: begin
				if (enabled_q && phase_q == ifds_pkg::PH_IDLE) begin
					n_origin = 1'b0; n_anchor = {1'b0, time_ns};
					n_phase = ifds_pkg::PH_WD_COUNT; n_act = ifds_pkg::ACT_COUNT;
				end
			end
			ifds_pkg::MODE_COUNT: begin
				unique case (phase_q)
					ifds_pkg::PH_WD_COUNT: begin
						if (ovf_flag || (word_count >= WTM_WORDS &&
								gap >= $signed({34'd0, wdgap_q}))) begin
							n_origin = 1'b0;
							n_phase = ifds_pkg::PH_PRE_COUNT; n_act = ifds_pkg::ACT_COUNT;
						end else begin
							do_finish = 1'b1;
						end
					end
					ifds_pkg::PH_PRE_COUNT: begin
						if (ovf_flag) begin
							n_phase = ifds_pkg::PH_OVF_CYCLE; n_act = ifds_pkg::ACT_CYCLE;
						end else if ((irq_origin_q && word_count < WTM_WORDS) ||
								frames == '0) begin
							do_finish = 1'b1;
						end else begin
							// An irq drain starts one period before the anchor; a
							// watchdog drain ends at the anchor.
							n_back = irq_origin_q ? FW'(1) : frames - FW'(1);
							n_first_ld = 1'b1;
							n_offset = '0; n_loop = '0; n_retry = '0; n_read_any = 1'b0;
							n_phase = ifds_pkg::PH_LOOP_COUNT; n_act = ifds_pkg::ACT_COUNT;
						end
					end
					ifds_pkg::PH_LOOP_COUNT: begin
						if (ovf_flag) begin
							n_phase = ifds_pkg::PH_FINAL_COUNT; n_act = ifds_pkg::ACT_COUNT;
						end else if (frames == '0) begin
							if (word_count != '0 && 32'(retry_q) < ifds_pkg::RETRY_LIMIT) begin
								n_retry = retry_q + 2'd1;
								n_phase = ifds_pkg::PH_DELAY; n_act = ifds_pkg::ACT_WAIT;
							end else begin
								n_phase = ifds_pkg::PH_FINAL_COUNT; n_act = ifds_pkg::ACT_COUNT;
							end
						end else begin
							n_pend = (frames > FW'(lim)) ? lim : BW'(frames);
							n_cnt = 6'(n_pend);
							n_phase = ifds_pkg::PH_READING; n_act = ifds_pkg::ACT_DATA;
						end
					end
					ifds_pkg::PH_FINAL_COUNT: begin
						if (read_any_q || word_count != '0 || ovf_flag) begin
							n_phase = ifds_pkg::PH_FINAL_CYCLE; n_act = ifds_pkg::ACT_CYCLE;
						end else begin
							n_err = '0; do_finish = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ifds_pkg::MODE_DATA: begin
				if (phase_q == ifds_pkg::PH_READING) begin
					n_read_any = 1'b1;
					n_offset = offset_q + 10'(pend_q);
					do_next_loop = 1'b1;
					do_stamps = (pend_q != '0);
				end
			end
			ifds_pkg::MODE_CYCLE: begin
				if (phase_q == ifds_pkg::PH_FINAL_CYCLE) begin
					n_err = '0; do_finish = 1'b1;
				end else if (phase_q == ifds_pkg::PH_OVF_CYCLE ||
						phase_q == ifds_pkg::PH_ERR_CYCLE) begin
					do_finish = 1'b1;
				end
			end
			ifds_pkg::MODE_REINIT: begin
				if (phase_q == ifds_pkg::PH_REINIT) begin
					n_err = '0; do_finish = 1'b1;
				end
			end
			ifds_pkg::MODE_DELAY: begin
				if (phase_q == ifds_pkg::PH_DELAY) do_next_loop = 1'b1;
			end
			default: begin
				if (phase_q inside {ifds_pkg::PH_WD_COUNT, ifds_pkg::PH_PRE_COUNT,
						ifds_pkg::PH_LOOP_COUNT, ifds_pkg::PH_READING,
						ifds_pkg::PH_FINAL_COUNT, ifds_pkg::PH_FINAL_CYCLE}) begin
					n_err = (err_q == 3'd7) ? err_q : err_q + 3'd1;
					if (n_err >= errlim_q) begin
						n_phase = ifds_pkg::PH_REINIT; n_act = ifds_pkg::ACT_REINIT;
					end else begin
						n_phase = ifds_pkg::PH_ERR_CYCLE; n_act = ifds_pkg::ACT_CYCLE;
					end
				end else if (phase_q inside {ifds_pkg::PH_OVF_CYCLE, ifds_pkg::PH_ERR_CYCLE,
						ifds_pkg::PH_REINIT}) begin
					do_finish = 1'b1;
				end
			end
		endcase

		if (do_next_loop) begin
			n_loop = loop_inc;
			if (32'(loop_inc) >= MAX_LOOPS) n_phase = ifds_pkg::PH_FINAL_COUNT;
			else n_phase = ifds_pkg::PH_LOOP_COUNT;
			n_act = ifds_pkg::ACT_COUNT;
		end
		if (do_finish) begin
			n_phase = ifds_pkg::PH_IDLE;
			if (enabled_q && irq_pending_q) begin
				n_pend_irq = 1'b0;
				n_origin = 1'b1; n_anchor = last_irq_q;
				n_phase = ifds_pkg::PH_PRE_COUNT; n_act = ifds_pkg::ACT_COUNT;
			end
		end
	end

	assign fin_act = n_act;

	assign sts.has_stamps  = do_stamps;
	assign sts.stamps_left = (stamps_q > BW'(1));

	// Stamp time for frame offset: first + offset*period, offset < 1024.
	logic [36:0] off_prod;
	assign off_prod = {27'd0, offset_q} * {10'd0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0; period_q <= 27'd625000; burst_q <= 6'(MAX_BURST);
			wdgap_q <= 30'd10000000; errlim_q <= 3'd3;
			phase_q <= ifds_pkg::PH_IDLE; irq_origin_q <= 1'b0; read_any_q <= 1'b0;
			irq_pending_q <= 1'b0; last_irq_q <= '0; anchor_q <= '0; first_q <= '0;
			offset_q <= '0; loop_q <= '0; retry_q <= '0; err_q <= '0; pend_q <= '0;
			stamps_q <= '0; back_q <= '0; first_ld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ifds_pkg::CFG_ENABLED: enabled_q <= cfg_data[0];
					ifds_pkg::CFG_PERIOD:  period_q  <= cfg_data[26:0];
					ifds_pkg::CFG_BURST:   burst_q   <= cfg_data[5:0];
					ifds_pkg::CFG_WDGAP:   wdgap_q   <= cfg_data[29:0];
					ifds_pkg::CFG_ERRLIM:  errlim_q  <= cfg_data[2:0];
					default: ;
				endcase
			end
			first_ld_q <= cmd.step & n_first_ld;
			if (first_ld_q) first_q <= anchor_q - {25'd0, back_prod};
			if (cmd.step) begin
				phase_q <= n_phase; irq_origin_q <= n_origin; read_any_q <= n_read_any;
				irq_pending_q <= n_pend_irq; last_irq_q <= n_last_irq;
				anchor_q <= n_anchor; offset_q <= n_offset; back_q <= n_back;
				loop_q <= n_loop; retry_q <= n_retry; err_q <= n_err; pend_q <= n_pend;
				stamps_q <= pend_q;
			end else if (cmd.stamp) begin
				stamps_q <= stamps_q - BW'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			tail_act_q <= fin_act;
			if (do_stamps) begin
				act_q <= ifds_pkg::ACT_STAMP; cnt_q <= 6'd0;
				time_q <= first_q + {27'd0, off_prod};
				last_q <= 1'b0;
			end else begin
				act_q <= fin_act; cnt_q <= n_cnt; time_q <= '0; last_q <= 1'b1;
			end
		end else if (cmd.stamp) begin
			time_q <= time_q + {37'd0, period_q};
		end else if (cmd.stamp_done) begin
			act_q <= tail_act_q; cnt_q <= 6'd0; time_q <= '0; last_q <= 1'b1;
		end
	end

	assign action      = act_q;
	assign frame_count = cnt_q;
	assign frame_time  = time_q;
	assign last        = last_q;

endmodule

/* sv/imu_fifo_drain_sequencer.sv */
// One item in, its results out in order, one result per cycle while not stalled.
// An item with no timestamps is answered with a single result; a data-read
// completion gives N frame timestamps and its command (up to 33 results) from
// the single timestamp adder, one frame per cycle while not stalled.
// One item is in work at a time; the next is taken after the last result.
// Reset (arst_n low, async) clears control state, loads register defaults.
module imu_fifo_drain_sequencer #(
	parameter int MAX_BURST       = 32,
	parameter int MAX_LOOPS       = 16,
	parameter int WORDS_PER_FRAME = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [62:0] time_ns,
	input  logic        ovf_flag,
	input  logic [11:0] word_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [5:0]  frame_count,
	output logic [63:0] frame_time,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ifds_pkg::ifds_cmd_t cmd;
	ifds_pkg::ifds_sts_t sts;
	logic busy, in_fire, out_fire;

	assign in_stall  = busy;
	assign in_fire   = in_valid && !busy;
	assign out_fire  = out_valid && !out_stall;
	assign cfg_ready = 1'b1;

	ifds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
	);

	ifds_dp #(
		.MAX_BURST(MAX_BURST), .MAX_LOOPS(MAX_LOOPS), .WORDS_PER_FRAME(WORDS_PER_FRAME)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .time_ns(time_ns), .ovf_flag(ovf_flag),
		.word_count(word_count), .cfg_we(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .action(action), .frame_count(frame_count),
		.frame_time(frame_time), .last(last)
	);

endmodule
